@@ design/sorted_region_range_lookup_core_assert.svh @@
// Assertion macros for the sorted region range lookup core.
// Expects signals named clk and rst in the including module.
`ifndef SORTED_REGION_RANGE_LOOKUP_CORE_ASSERT_SVH
`define SORTED_REGION_RANGE_LOOKUP_CORE_ASSERT_SVH

// same-cycle implication, held off during reset
`define SRRL_ASSERT_IMP(label, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
    else $error("srrl: same-cycle check failed");

// next-cycle implication, held off during reset
`define SRRL_ASSERT_NXT(label, a, b) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
    else $error("srrl: next-cycle check failed");

`endif

@@ design/srrl_pkg.sv @@
// Shared types and constants for the sorted region range lookup core.
// No dependencies.
package srrl_pkg;

  localparam int ADDR_W     = 64;
  localparam int COUNT_W    = 8;
  localparam int ENTRY_W    = 7;
  localparam int REG_ADDR_W = 3;

  localparam logic OP_LOAD   = 1'b0;
  localparam logic OP_LOOKUP = 1'b1;

  // register select bit of paddr
  localparam logic REG_SEL_COUNT = 1'b0;

  typedef struct packed {
    logic [ADDR_W-1:0] base;
    logic [ADDR_W-1:0] size;
  } region_t;

endpackage

@@ design/srrl_table.sv @@
// Region table: one synchronous memory of base and size pairs.
// One write port, one read port with registered read data. Uses srrl_pkg.
module srrl_table #(
  parameter int MAX_REGIONS = 128,
  parameter int IDX_W       = 7
) (
  input  logic                  clk,
  input  logic                  wr_en,
  input  logic [IDX_W-1:0]      wr_addr,
  input  srrl_pkg::region_t     wr_data,
  input  logic                  rd_en,
  input  logic [IDX_W-1:0]      rd_addr,
  output srrl_pkg::region_t     rd_data
);
  import srrl_pkg::*;

  region_t mem [MAX_REGIONS];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

@@ design/srrl_search.sv @@
// Binary search sequencer: one table probe per cycle, gap tracking, output register.
// Uses srrl_pkg and the assertion macros header.
`include "sorted_region_range_lookup_core_assert.svh"

module srrl_search #(
  parameter int IDX_W       = 7,
  parameter int CNT_W       = 8
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [srrl_pkg::ADDR_W-1:0]   query_addr,
  input  logic [CNT_W-1:0]              hi_init,
  output logic                          busy,
  output logic                          rd_en,
  output logic [IDX_W-1:0]              rd_addr,
  input  srrl_pkg::region_t             rd_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          found,
  output logic [srrl_pkg::ADDR_W-1:0]   range_start,
  output logic [srrl_pkg::ADDR_W-1:0]   range_end
);
  import srrl_pkg::*;

  localparam int SUM_W = CNT_W + 1;

  typedef enum logic [1:0] {S_IDLE, S_START, S_PROBE, S_DONE} state_t;

  state_t              state;
  logic [CNT_W-1:0]    lo;
  logic [CNT_W-1:0]    hi;
  logic [IDX_W-1:0]    mid_q;
  logic [ADDR_W-1:0]   query;
  logic [ADDR_W-1:0]   gap_start;
  logic [ADDR_W-1:0]   gap_end;
  logic                hit_q;

  logic [CNT_W-1:0]    lo_next;
  logic [CNT_W-1:0]    hi_next;
  logic [SUM_W-1:0]    mid_sum;
  logic [ADDR_W-1:0]   probe_end;
  logic                below;
  logic                above;
  logic                hit;

  always_comb begin
    lo_next   = lo;
    hi_next   = hi;
    hit       = 1'b0;
    probe_end = rd_data.base + rd_data.size;
    below     = query < rd_data.base;
    above     = query >= probe_end;
    if (state == S_PROBE) begin
      priority if (below) begin
        hi_next = CNT_W'(mid_q);
      end else if (above) begin
        lo_next = CNT_W'(mid_q) + CNT_W'(1);
      end else begin
        hit = 1'b1;
      end
    end
    mid_sum = SUM_W'(lo_next) + SUM_W'(hi_next);
    rd_addr = mid_sum[IDX_W:1];
    rd_en   = ((state == S_START) || ((state == S_PROBE) && !hit)) && (lo_next < hi_next);
  end

  assign busy = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready && (state != S_DONE)) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (start) begin
            lo        <= '0;
            hi        <= hi_init;
            query     <= query_addr;
            gap_start <= '0;
            gap_end   <= '1;
            hit_q     <= 1'b0;
            state     <= S_START;
          end
        end
        S_START, S_PROBE: begin
          if (state == S_PROBE) begin
            priority if (below) begin
              gap_end <= rd_data.base;
            end else if (above) begin
              gap_start <= probe_end;
            end else begin
              gap_start <= rd_data.base;
              gap_end   <= probe_end;
              hit_q     <= 1'b1;
            end
          end
          lo    <= lo_next;
          hi    <= hi_next;
          mid_q <= rd_addr;
          state <= rd_en ? S_PROBE : S_DONE;
        end
        S_DONE: begin
          if (!out_valid || out_ready) begin
            found       <= hit_q;
            range_start <= gap_start;
            range_end   <= gap_end;
            out_valid   <= 1'b1;
            state       <= S_IDLE;
          end
        end
      endcase
    end
  end

  `SRRL_ASSERT_IMP(a_start_idle, start, state == S_IDLE)
  `SRRL_ASSERT_IMP(a_probe_window, state == S_PROBE, lo < hi)
  `SRRL_ASSERT_IMP(a_probe_mid, state == S_PROBE, (CNT_W'(mid_q) >= lo) && (CNT_W'(mid_q) < hi))
  `SRRL_ASSERT_NXT(a_read_then_probe, rd_en, state == S_PROBE)

endmodule

@@ design/sorted_region_range_lookup_core.sv @@
// Top level of the sorted region range lookup core: register port, input decode.
// Instantiates srrl_table and srrl_search; uses srrl_pkg.
//
//   port group   | handshake              | contents
//   -------------+------------------------+------------------------------------
//   register     | psel/penable/pwrite    | region_count at byte address 0
//   input word   | in_valid / in_ready    | op, entry_index, entry_base/size, query_addr
//   output word  | out_valid / out_ready  | found, range_start, range_end
//
// A load word is written to the table at its accept edge. A lookup makes P table
// probes, at most floor(log2(region_count)) + 1 (8 for 128 entries), each one table read.
// in_ready is high only while no lookup is in progress; a lookup that finishes while
// the output word is stalled holds until it is taken. Reset clears region_count.
module sorted_region_range_lookup_core #(
  parameter int MAX_REGIONS = 128
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [srrl_pkg::REG_ADDR_W-1:0]   paddr,
  input  logic [31:0]                       pwdata,
  output logic [31:0]                       prdata,
  output logic                              pready,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic                              op,
  input  logic [srrl_pkg::ENTRY_W-1:0]      entry_index,
  input  logic [srrl_pkg::ADDR_W-1:0]       entry_base,
  input  logic [srrl_pkg::ADDR_W-1:0]       entry_size,
  input  logic [srrl_pkg::ADDR_W-1:0]       query_addr,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic                              found,
  output logic [srrl_pkg::ADDR_W-1:0]       range_start,
  output logic [srrl_pkg::ADDR_W-1:0]       range_end
);
  import srrl_pkg::*;

  localparam int IDX_W = (MAX_REGIONS > 1) ? $clog2(MAX_REGIONS) : 1;
  localparam int CNT_W = $clog2(MAX_REGIONS + 1);
  localparam int CMP_W = (CNT_W > COUNT_W) ? CNT_W : COUNT_W;
  localparam int IXE_W = (CMP_W > ENTRY_W) ? CMP_W : ENTRY_W;

  logic [COUNT_W-1:0] region_count;
  logic [CMP_W-1:0]   count_ext;
  logic [CNT_W-1:0]   hi_init;
  logic [IXE_W-1:0]   index_ext;
  logic               accept;
  logic               wr_en;
  logic [IDX_W-1:0]   wr_addr;
  region_t            wr_data;
  logic               rd_en;
  logic [IDX_W-1:0]   rd_addr;
  region_t            rd_data;
  logic               busy;
  logic               start;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      region_count <= '0;
    end else if (psel && penable && pwrite && (paddr[REG_ADDR_W-1] == REG_SEL_COUNT)) begin
      region_count <= pwdata[COUNT_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[REG_ADDR_W-1] == REG_SEL_COUNT) begin
      prdata = 32'(region_count);
    end
  end

  // clamp the searched count to the table depth
  always_comb begin
    count_ext = CMP_W'(region_count);
    if (count_ext > CMP_W'(MAX_REGIONS)) begin
      count_ext = CMP_W'(MAX_REGIONS);
    end
    hi_init = CNT_W'(count_ext);
  end

  assign in_ready  = !busy;
  assign accept    = in_valid && in_ready;
  assign start     = accept && (op == OP_LOOKUP);
  assign index_ext = IXE_W'(entry_index);
  assign wr_en     = accept && (op == OP_LOAD) && (index_ext < IXE_W'(MAX_REGIONS));
  assign wr_addr   = IDX_W'(index_ext);
  assign wr_data   = '{base: entry_base, size: entry_size};

  srrl_table #(
    .MAX_REGIONS (MAX_REGIONS),
    .IDX_W       (IDX_W)
  ) u_table (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  srrl_search #(
    .IDX_W       (IDX_W),
    .CNT_W       (CNT_W)
  ) u_search (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .query_addr  (query_addr),
    .hi_init     (hi_init),
    .busy        (busy),
    .rd_en       (rd_en),
    .rd_addr     (rd_addr),
    .rd_data     (rd_data),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .found       (found),
    .range_start (range_start),
    .range_end   (range_end)
  );

endmodule
